// ===== rtl/acbc_pkg.sv =====
// acbc_pkg: shared types, tables and round functions for the AES-128 CBC
// decryptor with padding check. No dependencies.
`default_nettype none

package acbc_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned AES_ROUNDS  = 10;
  localparam int unsigned RK_DEPTH    = AES_ROUNDS + 1;
  localparam int unsigned RK_AW       = $clog2(RK_DEPTH);
  localparam int unsigned CFG_IDX_W   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  // input opcodes
  localparam logic OP_LOAD_IV = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [RK_AW-1:0] RK_LAST = RK_AW'(AES_ROUNDS);

  typedef struct packed {
    logic        opcode;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        final_block;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        message_end;
    logic        padding_valid;
  } out_beat_t;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // inverse table built at elaboration
  function automatic sbox_t inv_tab();
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = i[7:0];
    end
    return t;
  endfunction

  localparam sbox_t INV_SBOX = inv_tab();

  function automatic logic [7:0] rcon(input logic [RK_AW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // one key schedule step: round key r from round key r-1
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // inverse shift rows and inverse sub bytes; byte i sits at bits 127-8i
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = INV_SBOX[s[127 - 8*(r + 4*((c - r + 4) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] mul_9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] mul_b(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] mul_d(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] mul_e(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] m0, m1, m2, m3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      // mul 9, 11, 13, 14 from doublings
      m0 = mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3);
      m1 = mul_9(a0) ^ mul_e(a1) ^ mul_b(a2) ^ mul_d(a3);
      m2 = mul_d(a0) ^ mul_9(a1) ^ mul_e(a2) ^ mul_b(a3);
      m3 = mul_b(a0) ^ mul_d(a1) ^ mul_9(a2) ^ mul_e(a3);
      t[127 - 32*c -: 32] = {m0, m1, m2, m3};
    end
    return t;
  endfunction

  // pkcs7 check on a plaintext block
  function automatic logic pad_ok(input logic [127:0] p);
    logic [7:0] n;
    logic ok;
    n  = p[7:0];
    ok = (n != 8'd0) && (n <= 8'(BLOCK_BYTES));
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if ((i >= BLOCK_BYTES - int'(n)) && (p[127 - 8*i -: 8] != n)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aes128_cbc_decrypt_pad_check.sv =====
// AES-128 CBC decryptor with PKCS#7 padding check on the last block.
// Depends on acbc_pkg and acbc_key_sched.
//
// Channels: input beats (in_valid_i/in_ready_o, in_data_i) carry an opcode
// and a 128-bit block; opcode load-IV sets the chain and gives no result,
// opcode decrypt gives one output beat (out_valid_o/out_ready_i, out_data_o)
// with plaintext, the message end flag and the padding verdict.
// The key is written over the cfg port in two 64-bit halves.
// Decrypt beats do not overlap: the next beat is taken in the cycle the
// previous result moves to the output register. The pace is set by the
// single shared inverse round unit, fed by the round key memory, one round
// per cycle unless a stalled receiver holds the final round. An IV load is
// taken when the core is free. Reset and every key write start a key
// expansion into the round key memory; in_ready_o is low meanwhile. The
// chain resets to zero.
// A stalled receiver holds the output register; the core then waits in its
// final round and in_ready_o stays low until the output frees up.
`default_nettype none

module aes128_cbc_decrypt_pad_check
  import acbc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [63:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_beat_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_beat_t                 out_data_o
);

  logic             ks_busy;
  logic [127:0]     rk;
  logic             rd_en;
  logic [RK_AW-1:0] rd_addr;

  logic             busy_q;
  logic [RK_AW-1:0] cnt_q;
  logic [127:0]     st_q, ct_q, chain_q;
  logic             fin_q;
  logic             out_valid_q;
  out_beat_t        out_q;

  logic [127:0] added, st_d, plain;
  logic         out_free, done, acc;

  acbc_key_sched u_ks (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rk),
    .busy_o     (ks_busy)
  );

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign done       = busy_q && (cnt_q == '0) && out_free;
  assign in_ready_o = !ks_busy && (!busy_q || done);
  assign acc        = in_valid_i && in_ready_o;

  // round key fetch one round ahead; hold on a stalled final round
  assign rd_en   = !(busy_q && (cnt_q == '0) && !out_free);
  assign rd_addr = (!busy_q || (cnt_q == '0)) ? RK_LAST : cnt_q - 1'b1;

  // shared inverse round
  assign added = inv_shift_sub(st_q) ^ rk;
  assign st_d  = (cnt_q == RK_LAST) ? (st_q ^ rk) : inv_mix(added);
  assign plain = added ^ chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      chain_q <= '0;
    end else begin
      if (busy_q && (cnt_q != '0)) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (done) begin
        chain_q <= ct_q;
        busy_q  <= 1'b0;
      end
      if (acc) begin
        if (in_data_i.opcode == OP_DECRYPT) begin
          busy_q <= 1'b1;
          cnt_q  <= RK_LAST;
        end else begin
          chain_q <= {in_data_i.block_high, in_data_i.block_low};
        end
      end
    end
  end

  // block state and saved ciphertext
  always_ff @(posedge clk_i) begin
    if (acc && (in_data_i.opcode == OP_DECRYPT)) begin
      st_q  <= {in_data_i.block_high, in_data_i.block_low};
      ct_q  <= {in_data_i.block_high, in_data_i.block_low};
      fin_q <= in_data_i.final_block;
    end else if (busy_q && (cnt_q != '0)) begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q.plain_high    <= plain[127:64];
      out_q.plain_low     <= plain[63:0];
      out_q.message_end   <= fin_q;
      out_q.padding_valid <= fin_q && pad_ok(plain);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/acbc_key_sched.sv =====
// acbc_key_sched: key registers, round key expansion sequencer and the
// round key memory. Depends on acbc_pkg.
`default_nettype none

module acbc_key_sched
  import acbc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [63:0]          cfg_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [RK_AW-1:0]     rd_addr_i,
  output logic      [127:0]         rd_data_o,
  output logic                      busy_o
);

  logic [63:0]      key_hi_q, key_lo_q;
  logic             exp_busy_q;
  logic [RK_AW-1:0] exp_cnt_q;
  logic [127:0]     prev_q;
  logic [127:0]     wdata;
  logic             wen;
  logic [127:0]     rk_mem [RK_DEPTH];

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // one round key per cycle
  assign wen   = exp_busy_q && (exp_cnt_q <= RK_LAST);
  assign wdata = (exp_cnt_q == '0) ? {key_hi_q, key_lo_q} : key_step(prev_q, rcon(exp_cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_busy_q <= 1'b1;
      exp_cnt_q  <= '0;
    end else if (cfg_we_i) begin
      exp_busy_q <= 1'b1;
      exp_cnt_q  <= '0;
    end else if (exp_busy_q) begin
      if (exp_cnt_q == RK_LAST + 1'b1) begin
        exp_busy_q <= 1'b0;
      end
      exp_cnt_q <= exp_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      prev_q <= wdata;
    end
  end

  // round key memory, registered read
  always_ff @(posedge clk_i) begin
    if (wen) begin
      rk_mem[exp_cnt_q] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_o <= rk_mem[rd_addr_i];
    end
  end

  assign busy_o = exp_busy_q;

endmodule

`default_nettype wire

// ===== rtl/acbc_checker.sv =====
// acbc_checker: port-level assertions for the CBC decryptor, bound to the
// top level. Depends on acbc_pkg.
`default_nettype none

module acbc_checker
  import acbc_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 cfg_we_i,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire in_beat_t             in_data_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire out_beat_t            out_data_o
);

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed under stall");

  // a decrypt beat occupies the round unit
  a_busy_after_decrypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode == OP_DECRYPT) |=> !in_ready_o)
    else $error("input taken while rounds in progress");

  // padding verdict only on the last block
  a_pad_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.padding_valid |-> out_data_o.message_end)
    else $error("padding flag on a non-final block");

  // key write starts expansion, no beat taken next cycle
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input taken during key expansion");

endmodule

bind aes128_cbc_decrypt_pad_check acbc_checker u_acbc_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for aes128_cbc_decrypt_pad_check (AES-128 CBC decrypt
// with PKCS#7 check). Depends on acbc_pkg and the RTL; a scoreboard class holds
// the predicted plaintext beats.
`timescale 1ns / 1ps

module tb
  import acbc_pkg::*;
();

  // ---------------------------------------------------------------------------
  // independent AES-128 inverse cipher, byte 0 at bits 127:120
  // ---------------------------------------------------------------------------
  typedef logic [7:0] byte_tab_t [256];

  function automatic byte_tab_t make_sbox();
    byte_tab_t t;
    logic [7:0] p, q, x;
    p = 8'h01;
    q = 8'h01;
    t[0] = 8'h63;
    // walk the multiplicative group with generator 3 and its inverse
    do begin
      p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
      t[p] = x ^ 8'h63;
    end while (p != 8'h01);
    return t;
  endfunction

  byte_tab_t fwd_sub, rev_sub;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] byte_at(logic [127:0] s, int i);
    return s[127 - 8*i -: 8];
  endfunction

  logic [127:0] sched [11];

  // rebuild all eleven round keys from the 128-bit key
  function automatic void expand(logic [127:0] key);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]], fwd_sub[t[31:24]]};
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] unshift_unsub(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*c) -: 8] = rev_sub[byte_at(s, r + 4*((c - r + 4) % 4))];
    return t;
  endfunction

  function automatic logic [127:0] unmix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] co [4];
    co = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = 8'h00;
        for (int k = 0; k < 4; k++)
          t[127 - 8*(4*c + r) -: 8] ^= gf_mul(byte_at(s, 4*c + k), co[(k - r + 4) % 4]);
      end
    return t;
  endfunction

  function automatic logic [127:0] inv_cipher(logic [127:0] ct);
    logic [127:0] s;
    s = ct ^ sched[10];
    for (int r = 9; r >= 1; r--) s = unmix(unshift_unsub(s) ^ sched[r]);
    return unshift_unsub(s) ^ sched[0];
  endfunction

  function automatic logic pkcs7_good(logic [127:0] p);
    int n;
    n = int'(p[7:0]);
    if (n < 1 || n > 16) return 1'b0;
    for (int i = 16 - n; i < 16; i++) if (byte_at(p, i) != n[7:0]) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------------
  class plain_board;
    logic [127:0] chain;
    out_beat_t    pending[$];
    int           errors;
    int           matched;
    int           pads_good;

    function void note_beat(in_beat_t b);
      logic [127:0] ct, pt;
      out_beat_t    e;
      ct = {b.block_high, b.block_low};
      if (b.opcode == OP_LOAD_IV) begin
        chain = ct;
        return;
      end
      pt = inv_cipher(ct) ^ chain;
      chain = ct;
      e.plain_high    = pt[127:64];
      e.plain_low     = pt[63:0];
      e.message_end   = b.final_block;
      e.padding_valid = b.final_block && pkcs7_good(pt);
      pending.push_back(e);
    endfunction

    function void check_beat(out_beat_t a);
      out_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      matched++;
      if (e.padding_valid) pads_good++;
      if (a.plain_high !== e.plain_high) begin
        $error("plain_high exp %h got %h", e.plain_high, a.plain_high); errors++;
      end
      if (a.plain_low !== e.plain_low) begin
        $error("plain_low exp %h got %h", e.plain_low, a.plain_low); errors++;
      end
      if (a.message_end !== e.message_end) begin
        $error("message_end exp %b got %b", e.message_end, a.message_end); errors++;
      end
      if (a.padding_valid !== e.padding_valid) begin
        $error("padding_valid exp %b got %b", e.padding_valid, a.padding_valid); errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, dut
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_KEY_HIGH;
  logic [63:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;

  always #2 clk = ~clk;

  aes128_cbc_decrypt_pad_check u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  plain_board board;
  logic [127:0] cur_key;
  int  sent;
  int  idle_cycles = 0;
  bit  hold_long;
  bit  sink_quiet;

  // ---------------------------------------------------------------------------
  // monitors: accepted beats feed the scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_beat(in_data);
    if (rst_n && out_valid && out_ready) board.check_beat(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_long = 1'b0;
      end
      if (sink_quiet || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        for (int i = 1; i < n; i++) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic op, logic [127:0] blk, logic fin);
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, block_high: blk[127:64], block_low: blk[63:0], final_block: fin};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic gap();
    int n;
    if (sink_quiet || $urandom_range(0, 2) != 0) return;
    in_valid <= 1'b0;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_key(logic [127:0] key);
    drain();
    cfg_we <= 1'b1; cfg_idx <= REG_KEY_HIGH; cfg_data <= key[127:64];
    @(posedge clk);
    cfg_idx <= REG_KEY_LOW; cfg_data <= key[63:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_key = key;
    expand(key);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // encrypt-free way to get well-padded plaintext: choose the ciphertext, then
  // pick the chain so the final plaintext carries the wanted padding
  task automatic send_padded_tail(int pad, bit corrupt);
    logic [127:0] ct, want, iv;
    ct = rand_block();
    want = rand_block();
    for (int i = 16 - pad; i < 16; i++) want[127 - 8*i -: 8] = pad[7:0];
    if (corrupt) want[127 - 8*(16 - pad) -: 8] ^= 8'h01 << $urandom_range(0, 7);
    iv = inv_cipher(ct) ^ want;
    send_beat(OP_LOAD_IV, iv, 1'($urandom_range(0, 1)));
    gap();
    send_beat(OP_DECRYPT, ct, 1'b1);
  endtask

  task automatic send_message();
    int len;
    len = $urandom_range(0, 4);
    send_beat(OP_LOAD_IV, rand_block(), 1'b0);
    for (int i = 0; i < len; i++) begin
      gap();
      send_beat(OP_DECRYPT, rand_block(), 1'b0);
    end
    gap();
    // last block: mostly good padding, some bad or random
    case ($urandom_range(0, 5))
      0:       send_beat(OP_DECRYPT, rand_block(), 1'b1);
      1:       send_padded_tail($urandom_range(2, 16), 1'b1);
      default: send_padded_tail($urandom_range(1, 16), 1'b0);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [127:0] keys [4];
    fwd_sub = make_sbox();
    for (int i = 0; i < 256; i++) rev_sub[fwd_sub[i]] = i[7:0];
    board = new();
    board.chain = '0;
    sent = 0; hold_long = 0; sink_quiet = 0;
    expand('0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero key, no IV loaded, extreme blocks
    send_beat(OP_DECRYPT, '0, 1'b0);
    send_beat(OP_DECRYPT, '1, 1'b1);
    send_beat(OP_LOAD_IV, '1, 1'b1);
    send_beat(OP_DECRYPT, {64'h0, 64'hffff_ffff_ffff_ffff}, 1'b1);
    // standard test vector key, then padding corner lengths
    write_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    send_padded_tail(1, 1'b0);
    send_padded_tail(16, 1'b0);
    send_padded_tail(16, 1'b1);
    send_padded_tail(7, 1'b1);
    begin
      logic [127:0] ct, iv;
      ct = rand_block();
      iv = inv_cipher(ct) ^ {120'h0, 8'h00};
      send_beat(OP_LOAD_IV, iv, 1'b0); send_beat(OP_DECRYPT, ct, 1'b1);
      iv = inv_cipher(ct) ^ {120'h0, 8'h11};
      send_beat(OP_LOAD_IV, iv, 1'b0); send_beat(OP_DECRYPT, ct, 1'b1);
    end
    // key change mid-chain keeps the chain
    send_beat(OP_LOAD_IV, rand_block(), 1'b0);
    send_beat(OP_DECRYPT, rand_block(), 1'b0);
    write_key('1);
    send_beat(OP_DECRYPT, rand_block(), 1'b1);

    // pressure: long receiver hold-off while blocks keep coming
    hold_long = 1'b1;
    sink_quiet = 1'b1;
    for (int i = 0; i < 6; i++) send_beat(OP_DECRYPT, rand_block(), i == 5);
    sink_quiet = 1'b0;
    drain();

    // random messages across several keys
    keys[0] = '0; keys[1] = '1;
    keys[2] = 128'hffffffffffffffff0000000000000000; keys[3] = rand_block();
    for (int k = 0; k < 4; k++) begin
      write_key(keys[k]);
      while (sent < 80 + (k + 1) * 430) begin
        if ($urandom_range(0, 9) == 0) send_beat(1'($urandom_range(0, 1)), rand_block(),
                                                 1'($urandom_range(0, 1)));
        else send_message();
        gap();
      end
    end
    drain();

    $display("run: %0d input beats, %0d plaintext beats checked, %0d with good padding, 6 keys",
             sent, board.matched, board.pads_good);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== aes128_cbc_decrypt_pad_check.f =====
rtl/acbc_pkg.sv
rtl/acbc_key_sched.sv
rtl/aes128_cbc_decrypt_pad_check.sv
rtl/acbc_checker.sv
tb/sv/tb.sv
